/* rtl/core/sac_pkg.sv */
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the set-associative cache hit/miss model.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int COUNT_BITS   = 40;
  localparam int WAY_OUT_BITS = 3;

  typedef struct packed {
    logic                    hit;
    logic [WAY_OUT_BITS-1:0] way;
  } lookup_t;

endpackage

/* rtl/core/set_assoc_cache_hit_miss_model.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss_model
// Set-associative cache model with age-based replacement and saturating
// hit and miss counters.
// ----------------------------------------------------------------------------
// After reset the block clears its tag/age RAM one set per cycle, with busy
// high. From then on the set row of each item is read from the RAM at the
// accept edge, and in the next cycle all ways are compared, the row is
// rewritten and the result registered. busy is high in the lookup state that
// follows an accept, so the block takes no new item while one is being looked up.
// out_valid marks each result for one cycle; it is registered from the
// lookup state, and the receiver cannot stall. LINE_BYTES and SET_COUNT
// must be powers of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_miss_model #(
  parameter int LINE_BYTES   = 64,
  parameter int SET_COUNT    = 64,
  parameter int WAY_COUNT    = 8,
  parameter int ADDRESS_BITS = 48,
  parameter int AGE_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [47:0]                          in_address,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [sac_pkg::WAY_OUT_BITS-1:0]     out_way_used,
  output logic [sac_pkg::COUNT_BITS-1:0]       out_hit_total,
  output logic [sac_pkg::COUNT_BITS-1:0]       out_miss_total
);
  import sac_pkg::*;

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SET_COUNT);
  localparam int IDX_W    = (SET_COUNT > 1) ? SET_BITS : 1;
  localparam int TAG_BITS = ADDRESS_BITS - OFF_BITS - SET_BITS;
  localparam int ROW_W    = WAY_COUNT * (TAG_BITS + AGE_BITS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]        set_r, set_nxt;
  logic [TAG_BITS-1:0]     tag_r, tag_nxt;
  logic [COUNT_BITS-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_BITS-1:0]   miss_cnt_r, miss_cnt_nxt;
  logic                    valid_r, valid_nxt;
  lookup_t                 res_r, res_nxt;

  logic [ADDRESS_BITS-1:0] addr;
  logic [IDX_W-1:0]        in_set;
  logic                    accept;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [ROW_W-1:0]        ram_rdata;
  logic [ROW_W-1:0]        row_upd;
  lookup_t                 status;

  assign addr   = ADDRESS_BITS'(in_address);
  assign in_set = IDX_W'((addr >> OFF_BITS) & ADDRESS_BITS'(SET_COUNT - 1));
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  sac_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SET_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_set),
    .rdata(ram_rdata)
  );

  sac_update #(
    .WAY_COUNT(WAY_COUNT),
    .TAG_BITS (TAG_BITS),
    .AGE_BITS (AGE_BITS)
  ) u_update (
    .row    (ram_rdata),
    .tag    (tag_r),
    .row_nxt(row_upd),
    .status (status)
  );

  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_LOOK);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_idx_r : set_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : row_upd;

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    set_nxt      = set_r;
    tag_nxt      = tag_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    valid_nxt    = 1'b0;
    res_nxt      = res_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(SET_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          set_nxt   = in_set;
          tag_nxt   = TAG_BITS'(addr >> (OFF_BITS + SET_BITS));
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_nxt   = status;
        valid_nxt = 1'b1;
        if (status.hit) begin
          if (hit_cnt_r != '1) begin
            hit_cnt_nxt = hit_cnt_r + 1'b1;
          end
        end else begin
          if (miss_cnt_r != '1) begin
            miss_cnt_nxt = miss_cnt_r + 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_idx_r  <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      valid_r    <= valid_nxt;
    end
    set_r <= set_nxt;
    tag_r <= tag_nxt;
    res_r <= res_nxt;
  end

  assign out_valid      = valid_r;
  assign out_hit        = res_r.hit;
  assign out_way_used   = res_r.way;
  assign out_hit_total  = hit_cnt_r;
  assign out_miss_total = miss_cnt_r;

endmodule

/* rtl/core/sac_ram.sv */
// ----------------------------------------------------------------------------
// sac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/sac_update.sv */
// ----------------------------------------------------------------------------
// sac_update
// Tag compare over all ways of one set, age update and victim choice.
// Produces the rewritten set row and the hit/way status of the item.
// ----------------------------------------------------------------------------
module sac_update #(
  parameter int WAY_COUNT = 8,
  parameter int TAG_BITS  = 36,
  parameter int AGE_BITS  = 16
) (
  input  logic [WAY_COUNT*(TAG_BITS+AGE_BITS)-1:0] row,
  input  logic [TAG_BITS-1:0]                      tag,
  output logic [WAY_COUNT*(TAG_BITS+AGE_BITS)-1:0] row_nxt,
  output sac_pkg::lookup_t                         status
);
  import sac_pkg::*;

  localparam int ENT_W = TAG_BITS + AGE_BITS;
  localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

  logic [TAG_BITS-1:0] tags [WAY_COUNT];
  logic [AGE_BITS-1:0] ages [WAY_COUNT];
  logic [AGE_BITS-1:0] aged [WAY_COUNT];
  logic                found;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    victim;
  logic [AGE_BITS-1:0] best;

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      tags[w] = row[w*ENT_W +: TAG_BITS];
      ages[w] = row[w*ENT_W+TAG_BITS +: AGE_BITS];
      aged[w] = (ages[w] == '1) ? ages[w] : ages[w] + 1'b1;
    end
  end

  // lowest matching way wins
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (tags[w] == tag) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // lowest way of greatest age after aging
  always_comb begin
    best   = aged[0];
    victim = '0;
    for (int w = 1; w < WAY_COUNT; w++) begin
      if (aged[w] > best) begin
        best   = aged[w];
        victim = WAY_W'(w);
      end
    end
  end

  always_comb begin
    row_nxt = row;
    if (found) begin
      row_nxt[hit_way*ENT_W+TAG_BITS +: AGE_BITS] = '0;
    end else begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        row_nxt[w*ENT_W+TAG_BITS +: AGE_BITS] = aged[w];
      end
      row_nxt[victim*ENT_W +: TAG_BITS]          = tag;
      row_nxt[victim*ENT_W+TAG_BITS +: AGE_BITS] = '0;
    end
  end

  assign status.hit = found;
  assign status.way = found ? WAY_OUT_BITS'(hit_way) : WAY_OUT_BITS'(victim);

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative cache hit/miss model. A queue of
// byte addresses (a short directed run, then random traffic, half of it aimed at
// four busy sets) feeds a start/busy driver with random idle bursts. A cache
// model with its own tag and age arrays predicts each lookup, and the monitor
// checks every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  import sac_pkg::*;

  localparam int LINE_BYTES   = 64;
  localparam int SET_COUNT    = 64;
  localparam int WAY_COUNT    = 8;
  localparam int ADDRESS_BITS = 48;
  localparam int AGE_BITS     = 16;

  localparam int LINE_SHIFT = $clog2(LINE_BYTES);
  localparam int SET_SHIFT  = $clog2(SET_COUNT);
  localparam int TAG_BITS   = ADDRESS_BITS - LINE_SHIFT - SET_SHIFT;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [AGE_BITS-1:0]   AGE_MAX   = '1;

  localparam int RANDOM_ITEMS = 830;
  localparam int QUIET_TAIL   = 150;

  typedef struct {
    logic [47:0] addr;
    bit          drain;
  } access_item_t;

  typedef struct {
    lookup_t               look;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;
  } lookup_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [47:0]           in_address = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_hit;
  logic [WAY_OUT_BITS-1:0] out_way_used;
  logic [COUNT_BITS-1:0] out_hit_total;
  logic [COUNT_BITS-1:0] out_miss_total;

  // cache model state
  logic [TAG_BITS-1:0]   tag_mem [SET_COUNT][WAY_COUNT];
  logic [AGE_BITS-1:0]   age_mem [SET_COUNT][WAY_COUNT];
  logic [COUNT_BITS-1:0] hits_seen;
  logic [COUNT_BITS-1:0] misses_seen;

  access_item_t   access_q[$];
  lookup_result_t lookup_q[$];
  access_item_t   next_item;
  lookup_result_t want;
  lookup_result_t predicted;
  logic           took_item = 1'b0;
  int             gap_left = 0;
  int             error_count = 0;

  set_assoc_cache_hit_miss_model #(
    .LINE_BYTES  (LINE_BYTES),
    .SET_COUNT   (SET_COUNT),
    .WAY_COUNT   (WAY_COUNT),
    .ADDRESS_BITS(ADDRESS_BITS),
    .AGE_BITS    (AGE_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_way_used  (out_way_used),
    .out_hit_total (out_hit_total),
    .out_miss_total(out_miss_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [47:0] make_addr(input logic [TAG_BITS-1:0] tag,
                                            input int unsigned set_idx,
                                            input int unsigned offset);
    return {tag, SET_SHIFT'(set_idx), LINE_SHIFT'(offset)};
  endfunction

  function automatic lookup_result_t model_lookup(input logic [47:0] addr);
    lookup_result_t      r;
    logic [TAG_BITS-1:0] tag;
    int unsigned         set_idx;
    int                  chosen;
    logic [AGE_BITS-1:0] age;
    logic [AGE_BITS-1:0] oldest;
    bit                  found;
    tag     = addr[ADDRESS_BITS-1:LINE_SHIFT+SET_SHIFT];
    set_idx = 32'(addr[LINE_SHIFT +: SET_SHIFT]);
    found   = 1'b0;
    chosen  = 0;
    oldest  = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!found && tag_mem[set_idx][w] == tag) begin
        found  = 1'b1;
        chosen = w;
      end
    end
    if (found) begin
      age_mem[set_idx][chosen] = '0;
      if (hits_seen != COUNT_MAX) hits_seen++;
    end else begin
      // age the whole set, then evict the lowest way of greatest age
      for (int w = 0; w < WAY_COUNT; w++) begin
        age = age_mem[set_idx][w];
        if (age != AGE_MAX) age++;
        age_mem[set_idx][w] = age;
        if (w == 0 || age > oldest) begin
          oldest = age;
          chosen = w;
        end
      end
      tag_mem[set_idx][chosen] = tag;
      age_mem[set_idx][chosen] = '0;
      if (misses_seen != COUNT_MAX) misses_seen++;
    end
    r.look.hit  = found;
    r.look.way  = WAY_OUT_BITS'(chosen);
    r.hit_total  = hits_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  task automatic push_access(input logic [47:0] addr, input bit drain);
    access_item_t it;
    it.addr  = addr;
    it.drain = drain;
    access_q.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      in_address <= '0;
    end else if (start && !took_item) begin
      // hold until accepted
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left = gap_left - 1;
    end else if (access_q.size() == 0) begin
      start <= 1'b0;
    end else if (access_q[0].drain && lookup_q.size() != 0) begin
      start <= 1'b0;
    end else begin
      next_item = access_q.pop_front();
      start      <= 1'b1;
      in_address <= next_item.addr;
      if (access_q.size() > QUIET_TAIL && $urandom_range(3, 0) == 0)
        gap_left = $urandom_range(15, 1);
    end
  end

  // monitor
  always @(posedge clk) begin
    took_item <= rst_n && start && busy === 1'b0;
    if (rst_n && out_valid === 1'b1) begin
      if (lookup_q.size() == 0) begin
        $error("result with no item pending");
        error_count++;
      end else begin
        want = lookup_q.pop_front();
        if (out_hit !== want.look.hit) begin
          $error("hit: expected %0h, got %0h", want.look.hit, out_hit);
          error_count++;
        end
        if (out_way_used !== want.look.way) begin
          $error("way_used: expected %0h, got %0h", want.look.way, out_way_used);
          error_count++;
        end
        if (out_hit_total !== want.hit_total) begin
          $error("hit_total: expected %0h, got %0h", want.hit_total, out_hit_total);
          error_count++;
        end
        if (out_miss_total !== want.miss_total) begin
          $error("miss_total: expected %0h, got %0h", want.miss_total, out_miss_total);
          error_count++;
        end
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      predicted = model_lookup(in_address);
      lookup_q.push_back(predicted);
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [TAG_BITS-1:0] tag_pool [12];
    int unsigned         hot_set [4];
    int unsigned         pick;
    logic [47:0]         addr;

    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        tag_mem[s][w] = '0;
        age_mem[s][w] = '0;
      end
    end
    hits_seen   = '0;
    misses_seen = '0;

    // zero tag hits an empty set, lowest of the matching ways
    push_access(48'h0, 1'b0);
    push_access(48'hFFFF_FFFF_FFFF, 1'b0);
    push_access(make_addr('1, 0, 0), 1'b0);
    push_access(48'h0, 1'b0);
    push_access(48'h0000_0000_003F, 1'b0);
    // fill one set, then evict along the age order
    for (int t = 1; t <= 8; t++) push_access(make_addr(TAG_BITS'(t), 5, t), 1'b0);
    push_access(make_addr('0, 5, 0), 1'b0);
    push_access(make_addr(TAG_BITS'(3), 5, 17), 1'b0);
    push_access(make_addr(TAG_BITS'(9), 5, 63), 1'b0);
    push_access(make_addr(TAG_BITS'(1), 5, 0), 1'b0);
    push_access(48'hAAAA_AAAA_AAAA, 1'b0);
    push_access(48'h5555_5555_5555, 1'b0);

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 12; i++) tag_pool[i] = TAG_BITS'({$urandom(), $urandom()});
    for (int i = 0; i < 4; i++) hot_set[i] = $urandom_range(SET_COUNT - 1, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(9, 0);
      if (pick < 5)
        addr = make_addr(tag_pool[$urandom_range(11, 0)], hot_set[$urandom_range(3, 0)],
                         $urandom_range(LINE_BYTES - 1, 0));
      else if (pick < 7)
        addr = make_addr(tag_pool[$urandom_range(11, 0)], $urandom_range(SET_COUNT - 1, 0),
                         $urandom_range(LINE_BYTES - 1, 0));
      else
        addr = 48'({$urandom(), $urandom()});
      push_access(addr, i % 200 == 0);
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (access_q.size() != 0 || start || lookup_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0 && lookup_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
